// File: design/height_to_normal_map_stencil_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the height-to-normal-map stencil core
// Concurrent checks that are compiled for simulation and vanish in synthesis.
// ---------------------------------------------------------------------------
`ifndef HEIGHT_TO_NORMAL_MAP_STENCIL_CORE_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_STENCIL_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check that is switched off while the reset is applied.
`define H2NM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that holds on every clock edge, reset included.
`define H2NM_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define H2NM_ASSERT(lbl, clk, rstn, prop, msg)
`define H2NM_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// File: design/h2nm_pkg.sv
// ---------------------------------------------------------------------------
// h2nm_pkg
// Shared widths, constants and types of the height-to-normal-map stencil.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package h2nm_pkg;

  // Field and register widths.
  localparam int PIX_W      = 8;
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Register reset values.
  localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd256;
  localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd256;

  // The z channel is always saturated.
  localparam logic [PIX_W-1:0] NORMAL_Z = 8'hFF;

  // Queue between the front and the back part.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_LVL_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } h2nm_cfg_e;

  // Stencil operands of one output word.
  typedef struct packed {
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] down;
    logic             frame_end;
  } h2nm_op_t;

  // Push request from the front part into the queue.
  typedef struct packed {
    logic     valid;
    h2nm_op_t op;
  } h2nm_push_t;

endpackage

`default_nettype wire

// File: design/h2nm_ram.sv
// ---------------------------------------------------------------------------
// h2nm_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module h2nm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/h2nm_front.sv
// ---------------------------------------------------------------------------
// h2nm_front
// Accepts pixel and flush words, tracks the raster position, keeps the two
// row stores and gathers the stencil operands for the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module h2nm_front import h2nm_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_red_i,
  input  wire logic [PIX_W-1:0]      pixel_green_i,
  input  wire logic [PIX_W-1:0]      pixel_blue_i,
  input  wire logic                  flush_i,
  input  wire logic                  q_room_i,
  output h2nm_push_t                 push_o
);

  localparam int CntW = $clog2(MAX_WIDTH);
  localparam int WidW = $clog2(MAX_WIDTH + 1);
  localparam int CmpW = (WidW > IMG_W_W) ? WidW : IMG_W_W;

  // Configuration registers.
  logic [IMG_W_W-1:0] img_w_q;
  logic [IMG_H_W-1:0] img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= IMG_W_RESET;
      img_h_q <= IMG_H_RESET;
    end else if (cfg_we_i) begin
      unique case (h2nm_cfg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[IMG_H_W-1:0];
      endcase
    end
  end

  // Effective frame size: width limited to 2..MAX_WIDTH, height at least 2.
  logic [CmpW-1:0]    width_ext;
  logic [WidW-1:0]    w_eff;
  logic [WidW-1:0]    w_m1;
  logic [CntW-1:0]    last_idx;
  logic [IMG_H_W-1:0] h_eff;

  assign width_ext = CmpW'(img_w_q);

  always_comb begin
    if (width_ext < CmpW'(2)) begin
      w_eff = WidW'(2);
    end else if (width_ext > CmpW'(MAX_WIDTH)) begin
      w_eff = WidW'(MAX_WIDTH);
    end else begin
      w_eff = WidW'(width_ext);
    end
  end

  assign w_m1     = w_eff - WidW'(1);
  assign last_idx = w_m1[CntW-1:0];
  assign h_eff    = (img_h_q < IMG_H_W'(2)) ? IMG_H_W'(2) : img_h_q;

  // Raster position, saturated to the current frame size.
  logic [CntW-1:0]    col_q, col_d, c_sat;
  logic [IMG_H_W-1:0] row_q, row_d, r_sat;
  logic               flush_phase, at_last, at_first;

  assign c_sat       = (WidW'(col_q) >= w_eff) ? last_idx : col_q;
  assign r_sat       = (row_q > h_eff) ? h_eff : row_q;
  assign flush_phase = (r_sat == h_eff);
  assign at_last     = (c_sat == last_idx);
  assign at_first    = (c_sat == '0);

  // Handshake and classification: a word outside its phase is dropped.
  logic accept, take, emit;

  assign in_stall_o = ~q_room_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign take       = accept & (flush_i ? flush_phase : ~flush_phase);
  assign emit       = flush_i | (r_sat != '0);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take) begin
      col_d = at_last ? '0 : c_sat + CntW'(1);
      if (flush_i) begin
        row_d = at_last ? '0 : r_sat;
      end else begin
        row_d = at_last ? r_sat + IMG_H_W'(1) : r_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Height is the HSL lightness of the pixel.
  logic [PIX_W-1:0] max_c, min_c, cur_h;
  logic [PIX_W:0]   sum_c;

  always_comb begin
    max_c = pixel_red_i;
    min_c = pixel_red_i;
    if (pixel_green_i > max_c) max_c = pixel_green_i;
    if (pixel_blue_i > max_c)  max_c = pixel_blue_i;
    if (pixel_green_i < min_c) min_c = pixel_green_i;
    if (pixel_blue_i < min_c)  min_c = pixel_blue_i;
  end

  assign sum_c = {1'b0, max_c} + {1'b0, min_c};
  assign cur_h = sum_c[PIX_W:1];

  // Memory stage registers.
  logic             s1_valid_q;
  logic             s1_flush_q;
  logic             s1_emit_q;
  logic             s1_first_q;
  logic             s1_last_q;
  logic             s1_row1_q;
  logic [CntW-1:0]  s1_col_q;
  logic [PIX_W-1:0] s1_cur_q;
  logic             s1_byp_c_q;
  logic             s1_byp_n_q;
  logic [PIX_W-1:0] s1_bm_q;
  logic [PIX_W-1:0] s1_bu_q;
  logic [PIX_W-1:0] left_hold_q;

  // Row store ports.
  logic [CntW-1:0]  ra_cur, ra_next;
  logic             row_we;
  logic [PIX_W-1:0] mid_cur_rd, mid_next_rd, up_rd;
  logic [PIX_W-1:0] mid_cur, mid_next, up_raw;

  assign ra_cur  = c_sat;
  assign ra_next = c_sat + CntW'(1);
  assign row_we  = s1_valid_q & ~s1_flush_q;

  // The middle row is kept twice so that two columns can be read at once.
  h2nm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_cur (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (s1_col_q),
    .wdata_i (s1_cur_q),
    .re_i    (take),
    .raddr_i (ra_cur),
    .rdata_o (mid_cur_rd)
  );

  h2nm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_next (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (s1_col_q),
    .wdata_i (s1_cur_q),
    .re_i    (take),
    .raddr_i (ra_next),
    .rdata_o (mid_next_rd)
  );

  h2nm_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (s1_col_q),
    .wdata_i (mid_cur),
    .re_i    (take),
    .raddr_i (ra_cur),
    .rdata_o (up_rd)
  );

  // A read that meets a write in the same cycle takes the new value instead.
  assign mid_cur  = s1_byp_c_q ? s1_bm_q : mid_cur_rd;
  assign mid_next = s1_byp_n_q ? s1_bm_q : mid_next_rd;
  assign up_raw   = s1_byp_c_q ? s1_bu_q : up_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_flush_q <= flush_i;
      s1_emit_q  <= emit;
      s1_first_q <= at_first;
      s1_last_q  <= at_last;
      s1_row1_q  <= (r_sat == IMG_H_W'(1));
      s1_col_q   <= c_sat;
      s1_cur_q   <= cur_h;
      s1_byp_c_q <= row_we & (s1_col_q == ra_cur);
      s1_byp_n_q <= row_we & (s1_col_q == ra_next);
      s1_bm_q    <= s1_cur_q;
      s1_bu_q    <= mid_cur;
    end
  end

  // The old middle value of this column is the left neighbour of the next.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_hold_q <= '0;
    end else if (s1_valid_q) begin
      left_hold_q <= mid_cur;
    end
  end

  // Stencil operands with mirrored borders.
  logic [PIX_W-1:0] op_right, op_left, op_up, op_down;

  assign op_right = s1_last_q ? left_hold_q : mid_next;
  assign op_left  = s1_first_q ? op_right : left_hold_q;

  always_comb begin
    if (s1_flush_q) begin
      op_up   = up_raw;
      op_down = up_raw;
    end else begin
      op_up   = s1_row1_q ? s1_cur_q : up_raw;
      op_down = s1_cur_q;
    end
  end

  assign push_o.valid        = s1_valid_q & s1_emit_q;
  assign push_o.op.left      = op_left;
  assign push_o.op.right     = op_right;
  assign push_o.op.up        = op_up;
  assign push_o.op.down      = op_down;
  assign push_o.op.frame_end = s1_flush_q & s1_last_q;

endmodule

`default_nettype wire

// File: design/h2nm_back.sv
// ---------------------------------------------------------------------------
// h2nm_back
// Operand queue, clamped central differences and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "height_to_normal_map_stencil_core_assert.svh"

module h2nm_back import h2nm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire h2nm_push_t  push_i,
  output logic             q_room_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [PIX_W-1:0] normal_x_o,
  output logic [PIX_W-1:0] normal_y_o,
  output logic [PIX_W-1:0] normal_z_o,
  output logic             frame_end_o
);

  // Twice the positive difference, saturated at full scale.
  function automatic logic [PIX_W-1:0] clamp_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    begin
      d = a - b;
      if (a <= b) begin
        clamp_diff = '0;
      end else if (d[PIX_W-1]) begin
        clamp_diff = '1;
      end else begin
        clamp_diff = {d[PIX_W-2:0], 1'b0};
      end
    end
  endfunction

  // Operand queue.
  h2nm_op_t           q_mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_LVL_W-1:0] level_q;
  logic               pop;
  logic               out_valid_q;
  h2nm_op_t           head;

  assign head     = q_mem_q[rd_ptr_q];
  assign pop      = (level_q != '0) & (~out_valid_q | ~out_stall_i);
  // One slot is kept free for the word that is still in the memory stage.
  assign q_room_o = (level_q <= Q_LVL_W'(Q_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      q_mem_q[wr_ptr_q] <= push_i.op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i.valid) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop)          rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      level_q <= level_q + Q_LVL_W'(push_i.valid) - Q_LVL_W'(pop);
    end
  end

  // Output register.
  logic [PIX_W-1:0] nx_q, ny_q;
  logic             fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= pop | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      nx_q <= clamp_diff(head.left, head.right);
      ny_q <= clamp_diff(head.up, head.down);
      fe_q <= head.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = nx_q;
  assign normal_y_o  = ny_q;
  assign normal_z_o  = NORMAL_Z;
  assign frame_end_o = fe_q;

  // The queue never holds more words than it has slots.
  `H2NM_ASSERT_NORST(a_level_bound, clk_i, !rst_ni || level_q <= Q_LVL_W'(Q_DEPTH), "queue level overflow")
  // The stall reserve leaves a free slot for every push.
  `H2NM_ASSERT(a_push_room, clk_i, rst_ni, push_i.valid |-> level_q < Q_LVL_W'(Q_DEPTH), "push into full queue")
  // A word leaving the queue always lands in the output register.
  `H2NM_ASSERT(a_pop_lands, clk_i, rst_ni, pop |=> out_valid_q, "popped word lost")

endmodule

`default_nettype wire

// File: design/height_to_normal_map_stencil_core.sv
// ---------------------------------------------------------------------------
// height_to_normal_map_stencil_core
// Streams RGB pixels in raster order and returns a normal-map pixel per
// height, one row late, from central differences with mirrored borders.
// The block accepts one word per clock cycle while in_stall_o is low: pixel
// words of the frame, then image_width flush words that push out the last
// row. The rate is set by the row stores, which take one read of the current
// and the next column and one write each cycle. A result reaches the output
// register via the memory stage and the operand queue; the first row yields
// no results. in_stall_o rises only when the four-entry operand queue holds
// three or more words, as one slot is kept for the word still in the memory
// stage, that is when the output side has been stalled. The row stores are
// not cleared after reset: every entry is written before it is used.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module height_to_normal_map_stencil_core import h2nm_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_red_i,
  input  wire logic [PIX_W-1:0]      pixel_green_i,
  input  wire logic [PIX_W-1:0]      pixel_blue_i,
  input  wire logic                  flush_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [PIX_W-1:0]           normal_x_o,
  output logic [PIX_W-1:0]           normal_y_o,
  output logic [PIX_W-1:0]           normal_z_o,
  output logic                       frame_end_o
);

  h2nm_push_t push;
  logic       q_room;

  // Front part: position tracking, row stores and operand gathering.
  h2nm_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .flush_i       (flush_i),
    .q_room_i      (q_room),
    .push_o        (push)
  );

  // Back part: queue, differences and output register.
  h2nm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .q_room_o    (q_room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .normal_x_o  (normal_x_o),
    .normal_y_o  (normal_y_o),
    .normal_z_o  (normal_z_o),
    .frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire
